// ===== src/ir_frame_pulse_encoder_top_assert.svh =====
// Assertion macros for the IR frame encoder
`ifndef IR_FRAME_PULSE_ENCODER_TOP_ASSERT_SVH
`define IR_FRAME_PULSE_ENCODER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define IFPE_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("ifpe assertion failed");
`define IFPE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("ifpe assertion failed");
`else
`define IFPE_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define IFPE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== src/ifpe_pkg.sv =====
package ifpe_pkg;

  localparam int FRAME_BITS = 16;
  localparam int FIELD_W    = 5;
  localparam int DUR_W      = 16;
  localparam int SEG_W      = 6;
  localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(2 * FRAME_BITS);

  localparam logic [DUR_W-1:0] LONG_RST  = 16'd1600;
  localparam logic [DUR_W-1:0] SHORT_RST = 16'd800;
  localparam logic [DUR_W-1:0] GAP_RST   = 16'd3000;

  typedef enum logic [1:0] {
    REG_LONG  = 2'd0,
    REG_SHORT = 2'd1,
    REG_GAP   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [DUR_W-1:0] long_us;
    logic [DUR_W-1:0] short_us;
    logic [DUR_W-1:0] gap_us;
  } timing_t;

  typedef struct packed {
    logic                  valid;
    logic [FRAME_BITS-1:0] frame;
  } frame_beat_t;

endpackage

// ===== src/ifpe_front.sv =====
module ifpe_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [ifpe_pkg::FIELD_W-1:0] target,
  input  logic [ifpe_pkg::FIELD_W-1:0] payload,
  output ifpe_pkg::frame_beat_t        head,
  input  logic                         pop
);

  logic [ifpe_pkg::FRAME_BITS-1:0] q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  logic [ifpe_pkg::FRAME_BITS-1:0] frame;

  // start bit, target, payload, check
  assign frame = {1'b1, target, payload, target ^ payload};

  assign in_tready  = (count_r != 2'd2);
  assign push       = in_tvalid && in_tready;
  assign head.valid = (count_r != 2'd0);
  assign head.frame = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= frame;
    end
  end

`include "ir_frame_pulse_encoder_top_assert.svh"
  `IFPE_ASSERT_SAME(a_pop_nonempty, clk, rst_n, pop, count_r != 2'd0)
  `IFPE_ASSERT_SAME(a_count_range, clk, rst_n, 1'b1, count_r != 2'd3)

endmodule

// ===== src/ifpe_back.sv =====
module ifpe_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ifpe_pkg::timing_t          timing,
  input  ifpe_pkg::frame_beat_t      head,
  output logic                       pop,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic                       level,
  output logic [ifpe_pkg::DUR_W-1:0] duration_us,
  output logic                       last
);

  logic                              busy_r, busy_nxt;
  logic [ifpe_pkg::SEG_W-1:0]        seg_r, seg_nxt;
  logic [ifpe_pkg::FRAME_BITS-1:0]   frame_r, frame_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic                              level_r, level_nxt;
  logic [ifpe_pkg::DUR_W-1:0]        dur_r, dur_nxt;
  logic                              last_r, last_nxt;
  logic                              emit, last_seg, half, bit_now;

  assign last_seg = (seg_r == ifpe_pkg::SEG_LAST);
  assign half     = seg_r[0];
  assign bit_now  = frame_r[ifpe_pkg::FRAME_BITS-1];
  assign emit     = busy_r && (!out_valid_r || out_tready);
  assign pop      = head.valid && (!busy_r || (emit && last_seg));

  always_comb begin
    busy_nxt      = busy_r;
    seg_nxt       = seg_r;
    frame_nxt     = frame_r;
    out_valid_nxt = out_valid_r && !out_tready;
    level_nxt     = level_r;
    dur_nxt       = dur_r;
    last_nxt      = last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      if (last_seg) begin
        level_nxt = 1'b0;
        dur_nxt   = timing.gap_us;
        last_nxt  = 1'b1;
        busy_nxt  = 1'b0;
      end else begin
        level_nxt = !half;
        dur_nxt   = (bit_now ^ half) ? timing.long_us : timing.short_us;
        last_nxt  = 1'b0;
        seg_nxt   = seg_r + ifpe_pkg::SEG_W'(1);
        if (half) begin
          frame_nxt = {frame_r[ifpe_pkg::FRAME_BITS-2:0], 1'b0};
        end
      end
    end
    if (pop) begin
      busy_nxt  = 1'b1;
      seg_nxt   = '0;
      frame_nxt = head.frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      seg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      seg_r       <= seg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
    level_r <= level_nxt;
    dur_r   <= dur_nxt;
    last_r  <= last_nxt;
  end

  assign out_tvalid  = out_valid_r;
  assign level       = level_r;
  assign duration_us = dur_r;
  assign last        = last_r;

`include "ir_frame_pulse_encoder_top_assert.svh"
  `IFPE_ASSERT_SAME(a_seg_range, clk, rst_n, busy_r, seg_r <= ifpe_pkg::SEG_LAST)
  `IFPE_ASSERT_SAME(a_last_low, clk, rst_n, out_valid_r && last_r, !level_r)
  `IFPE_ASSERT_NEXT(a_gap_ends, clk, rst_n, emit && last_seg && !head.valid,
                    !busy_r && out_valid_r && last_r)

endmodule

// ===== src/ir_frame_pulse_encoder_top.sv =====
// channel | dir | handshake             | payload
// in_     | in  | in_tvalid/in_tready   | in_tdata: target[4:0], payload[9:5]
// out_    | out | out_tvalid/out_tready | out_tdata: level[0], duration_us[16:1]; out_tlast
// cfg_    | in  | psel/penable, pready  | long 0x0, short 0x4, gap 0x8
// Each frame gives 33 beats, one per cycle while out_tready is high, set by the segment
// sequencer in the back end.
// A two-frame queue sits between front and back, so input beats are taken while a
// frame is still being sent. Synchronous active-low reset restores the default timing.
// An output stall holds the current beat and freezes the sequencer.
module ir_frame_pulse_encoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // target[4:0], payload[9:5], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // level[0], duration_us[16:1], zero pad
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  ifpe_pkg::timing_t     timing_r, timing_nxt;
  ifpe_pkg::frame_beat_t head;
  ifpe_pkg::reg_idx_t    idx;
  logic                  pop;
  logic                  wr_en;
  logic                  level;
  logic [15:0]           duration_us;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx        = ifpe_pkg::reg_idx_t'(cfg_paddr[3:2]);

  always_comb begin
    timing_nxt = timing_r;
    cfg_prdata = '0;
    unique case (idx)
      ifpe_pkg::REG_LONG: begin
        cfg_prdata = {16'd0, timing_r.long_us};
        if (wr_en) timing_nxt.long_us = cfg_pwdata[15:0];
      end
      ifpe_pkg::REG_SHORT: begin
        cfg_prdata = {16'd0, timing_r.short_us};
        if (wr_en) timing_nxt.short_us = cfg_pwdata[15:0];
      end
      ifpe_pkg::REG_GAP: begin
        cfg_prdata = {16'd0, timing_r.gap_us};
        if (wr_en) timing_nxt.gap_us = cfg_pwdata[15:0];
      end
      default: cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timing_r.long_us  <= ifpe_pkg::LONG_RST;
      timing_r.short_us <= ifpe_pkg::SHORT_RST;
      timing_r.gap_us   <= ifpe_pkg::GAP_RST;
    end else begin
      timing_r <= timing_nxt;
    end
  end

  ifpe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .target    (in_tdata[4:0]),
    .payload   (in_tdata[9:5]),
    .head      (head),
    .pop       (pop)
  );

  ifpe_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .timing      (timing_r),
    .head        (head),
    .pop         (pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .level       (level),
    .duration_us (duration_us),
    .last        (out_tlast)
  );

  assign out_tdata = {7'd0, duration_us, level};

endmodule

// ===== tb/ir_frame_pulse_encoder_top_tb.sv =====
module ir_frame_pulse_encoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          IDLE_LIMIT     = 2000;
  localparam int          MAX_RX_STALL   = 20;
  localparam int          MAX_TX_GAP     = 30;
  localparam int          SETTLE_CYCLES  = 4;
  localparam int          TAIL_CYCLES    = 50;
  localparam int          RANDOM_PHASES  = 6;
  localparam int          PHASE_FRAMES   = 48;
  localparam logic [3:0]  ADDR_UNMAPPED  = 4'hC;

  typedef struct packed {
    logic                       level;
    logic [ifpe_pkg::DUR_W-1:0] dur_us;
    logic                       last;
  } segment_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;     // target[4:0], payload[9:5], zero pad
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // level[0], duration_us[16:1], zero pad
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  ir_frame_pulse_encoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // timing as the encoder should currently hold it
  logic [ifpe_pkg::DUR_W-1:0] long_us_m  = ifpe_pkg::LONG_RST;
  logic [ifpe_pkg::DUR_W-1:0] short_us_m = ifpe_pkg::SHORT_RST;
  logic [ifpe_pkg::DUR_W-1:0] gap_us_m   = ifpe_pkg::GAP_RST;

  segment_t pending_segments[$];
  int       n_errors   = 0;
  int       n_frames   = 0;
  int       n_beats    = 0;
  int       n_settings = 1;
  int       burst_left = 0;

  function automatic void add_segment(input segment_t s);
    pending_segments.insert(pending_segments.size(), s);
  endfunction

  function automatic void encode_frame(input logic [ifpe_pkg::FIELD_W-1:0] tgt,
                                       input logic [ifpe_pkg::FIELD_W-1:0] pay);
    logic [ifpe_pkg::FRAME_BITS-1:0] frame;
    frame = {1'b1, tgt, pay, tgt ^ pay};
    for (int i = ifpe_pkg::FRAME_BITS - 1; i >= 0; i--) begin
      if (frame[i]) begin
        add_segment(segment_t'{1'b1, long_us_m, 1'b0});
        add_segment(segment_t'{1'b0, short_us_m, 1'b0});
      end else begin
        add_segment(segment_t'{1'b1, short_us_m, 1'b0});
        add_segment(segment_t'{1'b0, long_us_m, 1'b0});
      end
    end
    add_segment(segment_t'{1'b0, gap_us_m, 1'b1});
  endfunction

  function automatic logic [3:0] reg_addr(input ifpe_pkg::reg_idx_t r);
    return {r, 2'b00};
  endfunction

  function automatic logic [31:0] pick_duration();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'h0000_FFFF;
      3:       return $urandom;
      default: return $urandom_range(1, 4000);
    endcase
  endfunction

  function automatic logic [ifpe_pkg::FIELD_W-1:0] pick_field();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return ifpe_pkg::FIELD_W'($urandom);
    endcase
  endfunction

  function automatic void flag_mismatch(input string what, input int expd, input int got);
    n_errors++;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, expd, got);
  endfunction

  // all calls start and end on a rising edge
  task automatic write_reg(input logic [3:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (addr[3:2])
      ifpe_pkg::REG_LONG:  long_us_m  = data[ifpe_pkg::DUR_W-1:0];
      ifpe_pkg::REG_SHORT: short_us_m = data[ifpe_pkg::DUR_W-1:0];
      ifpe_pkg::REG_GAP:   gap_us_m   = data[ifpe_pkg::DUR_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_frame(input logic [ifpe_pkg::FIELD_W-1:0] tgt,
                            input logic [ifpe_pkg::FIELD_W-1:0] pay);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(20, 60);
      end else begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, MAX_TX_GAP)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, pay, tgt};
    do @(posedge clk); while (!in_tready);
    encode_frame(tgt, pay);
    burst_left--;
    n_frames++;
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_segments.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_default_timing();
    send_frame(5'd0, 5'd0);
    send_frame(5'd31, 5'd31);
    send_frame(5'd31, 5'd0);
    send_frame(5'd0, 5'd31);
    wait_drain();
  endtask

  task automatic test_walking_bits();
    for (int i = 0; i < ifpe_pkg::FIELD_W; i++) begin
      send_frame(ifpe_pkg::FIELD_W'(1 << i), 5'd0);
      send_frame(5'd0, ifpe_pkg::FIELD_W'(1 << i));
    end
    send_frame(5'd21, 5'd10);
    send_frame(5'd10, 5'd21);
    wait_drain();
  endtask

  // zero lengths must still come out as beats
  task automatic test_zero_durations();
    write_reg(reg_addr(ifpe_pkg::REG_LONG), 32'd0);
    write_reg(reg_addr(ifpe_pkg::REG_SHORT), 32'd0);
    write_reg(reg_addr(ifpe_pkg::REG_GAP), 32'd0);
    n_settings++;
    send_frame(5'd31, 5'd0);
    send_frame(5'd0, 5'd31);
    wait_drain();
  endtask

  task automatic test_max_durations();
    write_reg(reg_addr(ifpe_pkg::REG_LONG), 32'h0000_FFFF);
    write_reg(reg_addr(ifpe_pkg::REG_SHORT), 32'h0000_FFFF);
    write_reg(reg_addr(ifpe_pkg::REG_GAP), 32'h0000_FFFF);
    n_settings++;
    send_frame(5'd31, 5'd31);
    send_frame(5'd5, 5'd26);
    wait_drain();
  endtask

  // upper half of pwdata dropped; unmapped address leaves timing alone
  task automatic test_wide_writes();
    write_reg(reg_addr(ifpe_pkg::REG_LONG), 32'hA5A5_0123);
    write_reg(reg_addr(ifpe_pkg::REG_SHORT), 32'hFFFF_0045);
    write_reg(reg_addr(ifpe_pkg::REG_GAP), 32'h8000_0BB8);
    write_reg(ADDR_UNMAPPED, 32'h0000_0007);
    n_settings++;
    send_frame(5'd17, 5'd12);
    send_frame(5'd6, 5'd30);
    wait_drain();
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_reg(reg_addr(ifpe_pkg::REG_LONG), pick_duration());
      write_reg(reg_addr(ifpe_pkg::REG_SHORT), pick_duration());
      write_reg(reg_addr(ifpe_pkg::REG_GAP), pick_duration());
      if ($urandom_range(0, 2) == 0) write_reg(ADDR_UNMAPPED, $urandom);
      n_settings++;
      repeat (PHASE_FRAMES) send_frame(pick_field(), pick_field());
      wait_drain();
    end
  endtask

  // receiver: ready pattern changes mode every so often, stalls capped
  int rx_mode = 0;
  int rx_mode_left = 0;
  int rx_cyc = 0;
  int rx_stall_run = 0;

  always @(posedge clk) begin : rx_pattern
    logic rdy;
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(20, 200);
    end else begin
      rx_mode_left--;
    end
    rx_cyc++;
    case (rx_mode)
      0:       rdy = 1'b1;
      1:       rdy = ($urandom_range(0, 9) < 7);
      2:       rdy = ((rx_cyc % 5) != 0);
      default: rdy = ($urandom_range(0, 3) == 0);
    endcase
    if (rx_stall_run >= MAX_RX_STALL) rdy = 1'b1;
    rx_stall_run = rdy ? 0 : rx_stall_run + 1;
    out_tready <= rdy;
  end

  always @(posedge clk) begin : seg_check
    segment_t exp_seg;
    if (rst_n && out_tvalid && out_tready) begin
      n_beats++;
      if (pending_segments.size() == 0) begin
        flag_mismatch("unexpected beat", 0, int'(out_tdata));
      end else begin
        exp_seg = pending_segments.pop_front();
        if (out_tdata[0] !== exp_seg.level)
          flag_mismatch("level", int'(exp_seg.level), int'(out_tdata[0]));
        if (out_tdata[16:1] !== exp_seg.dur_us)
          flag_mismatch("duration_us", int'(exp_seg.dur_us), int'(out_tdata[16:1]));
        if (out_tlast !== exp_seg.last)
          flag_mismatch("last", int'(exp_seg.last), int'(out_tlast));
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d segments outstanding", $time,
               IDLE_LIMIT, pending_segments.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_timing();
    test_walking_bits();
    test_zero_durations();
    test_max_durations();
    test_wide_writes();
    test_random_phases();
    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Encoded %0d frames into %0d segment beats under %0d timing settings,",
             n_frames, n_beats, n_settings);
    $display("including zero, maximum and truncated register values.");
    if (n_errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
